// ----- rtl/fgnf_pkg.sv -----
`timescale 1ns / 1ps
package fgnf_pkg;

  localparam int MaxWidth   = 2048;
  localparam int SampleBits = 10;
  localparam int ColBits    = $clog2(MaxWidth);
  localparam int WidthBits  = 12;
  localparam int HeightBits = 13;
  localparam int RowBits    = HeightBits + 1;
  localparam int ThrBits    = 10;
  localparam int DiffBits   = SampleBits + 1;
  localparam int ProdBits   = 2 * SampleBits + 1;
  localparam int PairBits   = ProdBits + 1;
  localparam int AccBits    = ProdBits + 3;
  localparam int QuotBits   = SampleBits;
  localparam int DivBits    = ThrBits + 3;
  localparam int NumBanks   = 4;
  localparam int NumDirs    = 8;
  localparam int PaddrBits  = 4;

  typedef enum logic [1:0] {
    RegLineWidth   = 2'd0,
    RegFrameHeight = 2'd1,
    RegThreshold   = 2'd2
  } reg_idx_e;

  localparam int DirDy [NumDirs] = '{-1, 1, 0, 0, -1, -1, 1, 1};
  localparam int DirDx [NumDirs] = '{0, 0, -1, 1, -1, 1, -1, 1};

  typedef struct packed {
    logic                  vld;
    logic                  filt;
    logic                  last;
    logic [SampleBits-1:0] centre;
  } side_t;

endpackage

// ----- rtl/fgnf_ram.sv -----
`timescale 1ns / 1ps
module fgnf_ram #(
  parameter int Width = 10,
  parameter int Depth = 2048
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/fgnf_div.sv -----
`timescale 1ns / 1ps
module fgnf_div import fgnf_pkg::*; (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       en_i,
  input  logic signed [AccBits-1:0]  num_i,
  input  logic [DivBits-1:0]         div_i,
  input  side_t                      side_i,
  output logic signed [QuotBits:0]   quot_o,
  output side_t                      side_o
);

  // floor(n/d) for n < 0 is ~(~n / d)
  logic [AccBits-1:0]  rem_q  [QuotBits+1];
  logic [QuotBits-1:0] quo_q  [QuotBits+1];
  logic                neg_q  [QuotBits+1];
  side_t               side_q [QuotBits+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s <= QuotBits; s++) begin
        side_q[s] <= '0;
      end
    end else if (en_i) begin
      side_q[0] <= side_i;
      for (int s = 0; s < QuotBits; s++) begin
        side_q[s+1] <= side_q[s];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0] <= num_i[AccBits-1] ? ~num_i : num_i;
      neg_q[0] <= num_i[AccBits-1];
      quo_q[0] <= '0;
    end
  end

  for (genvar s = 0; s < QuotBits; s++) begin : g_stage
    localparam int Bit = QuotBits - 1 - s;
    logic [AccBits-1:0] dsh;
    logic               ge;
    assign dsh = AccBits'(div_i) << Bit;
    assign ge  = rem_q[s] >= dsh;
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[s+1] <= ge ? rem_q[s] - dsh : rem_q[s];
        quo_q[s+1] <= quo_q[s] | (ge ? (QuotBits'(1) << Bit) : QuotBits'(0));
        neg_q[s+1] <= neg_q[s];
      end
    end
  end

  assign quot_o = neg_q[QuotBits] ? $signed(~{1'b0, quo_q[QuotBits]})
                                  : $signed({1'b0, quo_q[QuotBits]});
  assign side_o = side_q[QuotBits];

endmodule

// ----- rtl/fuzzy_gradient_noise_filter_core.sv -----
`timescale 1ns / 1ps
// Fuzzy gradient noise filter on a raster stream of value samples, 5x5 window,
// one beat per clock sustained. A result for pixel (r, c) leaves two lines and
// two beats of input after its sample, and is registered through the window,
// gradient, product, pair-sum, divider and output stages; the rate is set by
// the four line-store RAMs (2048 x 10 each, one read and one write a cycle)
// and the bit-per-stage divider that scales the correction by the threshold.
// Pixels within two of a frame edge pass unchanged. Flush beats drain the last
// two lines once all samples of a frame are in. Any output stall freezes the
// whole pipeline. Line stores need no clearing after reset.
module fuzzy_gradient_noise_filter_core import fgnf_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [SampleBits-1:0] v_sample_i,
  input  logic                  flush_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [SampleBits-1:0] v_out_o,
  output logic                  frame_end_o,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [PaddrBits-1:0]  paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);

  function automatic logic signed [DiffBits-1:0] sdiff(input logic [SampleBits-1:0] a,
                                                       input logic [SampleBits-1:0] b);
    return $signed({1'b0, a}) - $signed({1'b0, b});
  endfunction

  function automatic logic [SampleBits-1:0] mag(input logic signed [DiffBits-1:0] v);
    logic signed [DiffBits-1:0] n;
    n = v[DiffBits-1] ? -v : v;
    return n[SampleBits-1:0];
  endfunction

  logic [WidthBits-1:0]  lw_q, lw_d;
  logic [HeightBits-1:0] fh_q, fh_d;
  logic [ThrBits-1:0]    thr_q, thr_d;
  logic                  cfg_wr;
  reg_idx_e              cfg_idx;

  logic [ColBits-1:0] col_q, col_d;
  logic [RowBits-1:0] row_q, row_d;

  logic                  adv;
  logic [WidthBits-1:0]  w_eff;
  logic [HeightBits-1:0] h_eff;
  logic [ThrBits-1:0]    t_eff;
  logic                  draining, step, emit, filt, last;
  logic [WidthBits-1:0]  col_inc;
  logic [RowBits-1:0]    row_inc;

  logic [SampleBits-1:0] bank_rd [NumBanks];

  logic                  s1_vld_q, s1_emit_q, s1_filt_q, s1_last_q;
  logic [SampleBits-1:0] s1_smp_q;
  logic [1:0]            s1_rsel_q;

  logic [SampleBits-1:0] win_q [5][5];
  logic                  s2_vld_q, s2_filt_q, s2_last_q;

  logic signed [DiffBits-1:0] g0_c [NumDirs];
  logic [ThrBits-1:0]         wt_c [NumDirs];

  logic signed [DiffBits-1:0] s3_g0_q [NumDirs];
  logic [ThrBits-1:0]         s3_wt_q [NumDirs];
  side_t                      s3_side_q;

  logic signed [ProdBits-1:0] s4_p_q [NumDirs];
  side_t                      s4_side_q;

  logic signed [PairBits-1:0] s5_q [NumDirs/2];
  side_t                      s5_side_q;

  logic signed [AccBits-1:0]  num_c;
  logic signed [QuotBits:0]   quot;
  side_t                      dv_side;
  logic signed [SampleBits+1:0] res_c;
  logic [SampleBits-1:0]      val_c;

  logic                  out_valid_q;
  logic [SampleBits-1:0] v_out_q;
  logic                  frame_end_q;

  // config port
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = reg_idx_e'(paddr[3:2]);

  always_comb begin
    lw_d  = lw_q;
    fh_d  = fh_q;
    thr_d = thr_q;
    prdata = '0;
    case (cfg_idx)
      RegLineWidth: begin
        prdata = 32'(lw_q);
        if (cfg_wr) lw_d = pwdata[WidthBits-1:0];
      end
      RegFrameHeight: begin
        prdata = 32'(fh_q);
        if (cfg_wr) fh_d = pwdata[HeightBits-1:0];
      end
      RegThreshold: begin
        prdata = 32'(thr_q);
        if (cfg_wr) thr_d = pwdata[ThrBits-1:0];
      end
      default: begin
        prdata = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lw_q  <= WidthBits'(640);
      fh_q  <= HeightBits'(480);
      thr_q <= ThrBits'(64);
    end else begin
      lw_q  <= lw_d;
      fh_q  <= fh_d;
      thr_q <= thr_d;
    end
  end

  assign w_eff = (lw_q < WidthBits'(5)) ? WidthBits'(5) :
                 (lw_q > WidthBits'(MaxWidth)) ? WidthBits'(MaxWidth) : lw_q;
  assign h_eff = (fh_q < HeightBits'(5)) ? HeightBits'(5) : fh_q;
  assign t_eff = (thr_q == '0) ? ThrBits'(1) : thr_q;

  // input position and step control
  assign adv        = !out_valid_q || out_ready_i;
  assign in_ready_o = adv;

  assign draining = row_q >= RowBits'(h_eff);
  assign step     = in_valid_i && adv && !(flush_i && !draining);
  assign emit     = (row_q >= RowBits'(3)) || (row_q == RowBits'(2) && col_q >= ColBits'(2));
  assign filt     = !draining && row_q >= RowBits'(4) && col_q >= ColBits'(4);
  assign last     = col_q == ColBits'(1) && row_q == RowBits'(h_eff) + RowBits'(2);
  assign col_inc  = WidthBits'(col_q) + WidthBits'(1);
  assign row_inc  = row_q + RowBits'(1);

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (cfg_wr && (cfg_idx == RegLineWidth || cfg_idx == RegFrameHeight)) begin
      col_d = '0;
      row_d = '0;
    end else if (step) begin
      if (last) begin
        col_d = '0;
        row_d = '0;
      end else if (col_inc >= w_eff) begin
        col_d = '0;
        row_d = (row_inc > RowBits'(h_eff) + RowBits'(2)) ? '0 : row_inc;
      end else begin
        col_d = col_inc[ColBits-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  // line stores, bank = row mod 4
  for (genvar b = 0; b < NumBanks; b++) begin : g_bank
    fgnf_ram #(
      .Width (SampleBits),
      .Depth (MaxWidth)
    ) u_ram (
      .clk_i   (clk_i),
      .we_i    (step && !draining && row_q[1:0] == 2'(b)),
      .waddr_i (col_q),
      .wdata_i (v_sample_i),
      .re_i    (adv),
      .raddr_i (col_q),
      .rdata_o (bank_rd[b])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else if (adv) begin
      s1_vld_q <= step;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_emit_q <= emit;
      s1_filt_q <= filt;
      s1_last_q <= last;
      s1_smp_q  <= v_sample_i;
      s1_rsel_q <= row_q[1:0];
    end
  end

  // window shift
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int y = 0; y < 5; y++) begin
        for (int x = 0; x < 5; x++) begin
          win_q[y][x] <= '0;
        end
      end
      s2_vld_q <= 1'b0;
    end else if (adv) begin
      s2_vld_q <= s1_vld_q && s1_emit_q;
      if (s1_vld_q) begin
        for (int y = 0; y < 5; y++) begin
          for (int x = 0; x < 4; x++) begin
            win_q[y][x] <= win_q[y][x+1];
          end
        end
        for (int y = 0; y < 4; y++) begin
          win_q[y][4] <= bank_rd[2'(s1_rsel_q + 2'(y))];
        end
        win_q[4][4] <= s1_smp_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s2_filt_q <= s1_filt_q;
      s2_last_q <= s1_last_q;
    end
  end

  // gradients and fuzzy weights
  always_comb begin
    logic signed [DiffBits-1:0] g1, g2;
    logic [SampleBits-1:0]      m;
    for (int k = 0; k < NumDirs; k++) begin
      g0_c[k] = sdiff(win_q[2+DirDy[k]][2+DirDx[k]], win_q[2][2]);
      g1 = sdiff(win_q[2+DirDx[k]+DirDy[k]][2-DirDy[k]+DirDx[k]],
                 win_q[2+DirDx[k]][2-DirDy[k]]);
      g2 = sdiff(win_q[2-DirDx[k]+DirDy[k]][2+DirDy[k]+DirDx[k]],
                 win_q[2-DirDx[k]][2+DirDy[k]]);
      m = mag(g0_c[k]);
      if (mag(g1) < m) m = mag(g1);
      if (mag(g2) < m) m = mag(g2);
      if (m > t_eff) m = t_eff;
      wt_c[k] = t_eff - m;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_side_q <= '0;
      s4_side_q <= '0;
      s5_side_q <= '0;
    end else if (adv) begin
      s3_side_q <= '{vld: s2_vld_q, filt: s2_filt_q, last: s2_last_q, centre: win_q[2][2]};
      s4_side_q <= s3_side_q;
      s5_side_q <= s4_side_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int k = 0; k < NumDirs; k++) begin
        s3_g0_q[k] <= g0_c[k];
        s3_wt_q[k] <= wt_c[k];
        s4_p_q[k]  <= ProdBits'(s3_g0_q[k] * $signed({1'b0, s3_wt_q[k]}));
      end
      for (int j = 0; j < NumDirs / 2; j++) begin
        s5_q[j] <= PairBits'(s4_p_q[2*j]) + PairBits'(s4_p_q[2*j+1]);
      end
    end
  end

  // num + 4T, then floor divide by 8T
  assign num_c = AccBits'(s5_q[0]) + AccBits'(s5_q[1]) + AccBits'(s5_q[2])
               + AccBits'(s5_q[3]) + $signed(AccBits'({t_eff, 2'b00}));

  fgnf_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (adv),
    .num_i  (num_c),
    .div_i  ({t_eff, 3'b000}),
    .side_i (s5_side_q),
    .quot_o (quot),
    .side_o (dv_side)
  );

  assign res_c = $signed({2'b00, dv_side.centre}) + (SampleBits+2)'(quot);

  always_comb begin
    if (!dv_side.filt) begin
      val_c = dv_side.centre;
    end else if (res_c < 0) begin
      val_c = '0;
    end else if (res_c > $signed((SampleBits+2)'((1 << SampleBits) - 1))) begin
      val_c = '1;
    end else begin
      val_c = res_c[SampleBits-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= dv_side.vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      v_out_q     <= val_c;
      frame_end_q <= dv_side.last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign v_out_o     = v_out_q;
  assign frame_end_o = frame_end_q;

endmodule
